// ===== hw/rtl/lwup_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the LCD window update packetizer.
// No dependencies; imported by every module of the block.
package lwup_pkg;

    localparam int COORD_W = 9;
    localparam int PIX_W   = 16;
    localparam int IDX_W   = 4;

    // Clamp limit for the exclusive column and row bounds.
    localparam logic [COORD_W-1:0] PANEL_LONG_SIDE = 9'd480;

    localparam logic [7:0] PFX_CMD   = 8'h11;
    localparam logic [7:0] PFX_DATA  = 8'h15;
    localparam logic [7:0] PFX_RESET = 8'h00;

    localparam logic [7:0] CMD_COL_SET   = 8'h2A;
    localparam logic [7:0] CMD_PAGE_SET  = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;
    localparam logic [7:0] CMD_MADCTL    = 8'h36;

    // Packet counts per item kind.
    localparam logic [IDX_W-1:0] NPKT_NONE  = 4'd0;
    localparam logic [IDX_W-1:0] NPKT_ONE   = 4'd1;
    localparam logic [IDX_W-1:0] NPKT_TWO   = 4'd2;
    localparam logic [IDX_W-1:0] NPKT_FLUSH = 4'd11;

    // Register indexes of the configuration port.
    localparam logic REG_DISPLAY_ENABLED = 1'b0;
    localparam logic REG_ROTATION_INDEX  = 1'b1;

    typedef enum logic [2:0] {
        OP_DAMAGE   = 3'd0,
        OP_FLUSH    = 3'd1,
        OP_PIXEL    = 3'd2,
        OP_ROTATION = 3'd3,
        OP_RESET    = 3'd4
    } t_opcode;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_value;
        logic [COORD_W-1:0] y_end;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_start;
        t_opcode            opcode;
    } t_item;

    typedef struct packed {
        logic [7:0] packet_prefix;
        logic [7:0] byte_high;
        logic [7:0] byte_low;
        logic       last_packet;
        logic       window_complete;
    } t_pkt;

    function automatic logic [7:0] rot_code(input logic [1:0] idx);
        logic [7:0] code;
        unique case (idx)
            2'd0:    code = 8'h0A;
            2'd1:    code = 8'h6A;
            2'd2:    code = 8'hCA;
            default: code = 8'hAA;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/lwup_out_reg.sv =====
`timescale 1ns / 1ps
// Output register of the packetizer: holds one packet beat for the stream sink.
// Depends on lwup_pkg for the packet struct.
module lwup_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pkt_valid,
    input  lwup_pkg::t_pkt i_pkt,
    output logic          o_ready,
    output logic          o_valid,
    output lwup_pkg::t_pkt o_pkt,
    input  logic          i_sink_ready
);
    import lwup_pkg::*;

    logic r_valid;
    t_pkt r_pkt;

    assign o_ready = !r_valid || i_sink_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_pkt_valid;
        end
    end

    // Load a new beat whenever the held one is gone or taken this cycle.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_pkt_valid) begin
            r_pkt <= i_pkt;
        end
    end

    assign o_valid = r_valid;
    assign o_pkt   = r_pkt;

endmodule

// ===== hw/rtl/lwup_core.sv =====
`timescale 1ns / 1ps
// Item register, dirty rectangle and pixel window state, and packet sequencer.
// Depends on lwup_pkg for item and packet types and packet codes.
module lwup_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_display_enabled,
    input  logic [1:0]     i_rotation_index,
    input  logic           i_item_valid,
    input  lwup_pkg::t_item i_item,
    output logic           o_item_ready,
    output logic           o_pkt_valid,
    output lwup_pkg::t_pkt  o_pkt,
    input  logic           i_pkt_ready
);
    import lwup_pkg::*;

    logic               r_busy;
    t_item              r_item;
    logic [IDX_W-1:0]   r_idx;

    logic [COORD_W-1:0] r_pend_xs, r_pend_ys, r_pend_xe, r_pend_ye;
    logic               r_pend_valid;
    logic [COORD_W-1:0] r_win_left, r_win_right, r_win_bottom;
    logic [COORD_W-1:0] r_cur_col, r_cur_row;
    logic               r_win_open;

    logic [COORD_W-1:0] n_pend_xs, n_pend_ys, n_pend_xe, n_pend_ye;
    logic               n_pend_valid;
    logic [COORD_W-1:0] n_win_left, n_win_right, n_win_bottom;
    logic [COORD_W-1:0] n_cur_col, n_cur_row;
    logic               n_win_open;

    logic [COORD_W-1:0] xe_c, ye_c, x_last, y_last, col_inc, row_inc;
    logic [IDX_W-1:0]   npkts;
    logic               is_last, step, finish, pix_done;
    t_pkt               pkt;

    assign xe_c   = (r_item.x_end > PANEL_LONG_SIDE) ? PANEL_LONG_SIDE : r_item.x_end;
    assign ye_c   = (r_item.y_end > PANEL_LONG_SIDE) ? PANEL_LONG_SIDE : r_item.y_end;
    assign x_last = r_pend_xe - 9'd1;
    assign y_last = r_pend_ye - 9'd1;
    assign col_inc = r_cur_col + 9'd1;
    assign row_inc = r_cur_row + 9'd1;
    assign pix_done = r_win_open && (col_inc >= r_win_right) && (row_inc >= r_win_bottom);

    always_comb begin
        unique case (r_item.opcode)
            OP_FLUSH:    npkts = (i_display_enabled && r_pend_valid) ? NPKT_FLUSH : NPKT_NONE;
            OP_PIXEL:    npkts = NPKT_ONE;
            OP_ROTATION: npkts = NPKT_TWO;
            OP_RESET:    npkts = NPKT_TWO;
            default:     npkts = NPKT_NONE;
        endcase
    end

    assign is_last     = (r_idx == npkts - 4'd1);
    assign o_pkt_valid = r_busy && (npkts != NPKT_NONE);
    assign step        = r_busy && ((npkts == NPKT_NONE) || i_pkt_ready);
    assign finish      = step && ((npkts == NPKT_NONE) || is_last);
    assign o_item_ready = !r_busy || finish;

    // Packet for the current sequencer position.
    always_comb begin
        pkt = '0;
        pkt.last_packet = is_last;
        unique case (r_item.opcode)
            OP_FLUSH: begin
                pkt.packet_prefix = PFX_DATA;
                unique case (r_idx)
                    4'd0: begin
                        pkt.packet_prefix = PFX_CMD;
                        pkt.byte_low      = CMD_COL_SET;
                    end
                    4'd1: pkt.byte_low = {7'd0, r_pend_xs[8]};
                    4'd2: pkt.byte_low = r_pend_xs[7:0];
                    4'd3: pkt.byte_low = {7'd0, x_last[8]};
                    4'd4: pkt.byte_low = x_last[7:0];
                    4'd5: begin
                        pkt.packet_prefix = PFX_CMD;
                        pkt.byte_low      = CMD_PAGE_SET;
                    end
                    4'd6: pkt.byte_low = {7'd0, r_pend_ys[8]};
                    4'd7: pkt.byte_low = r_pend_ys[7:0];
                    4'd8: pkt.byte_low = {7'd0, y_last[8]};
                    4'd9: pkt.byte_low = y_last[7:0];
                    default: begin
                        pkt.packet_prefix = PFX_CMD;
                        pkt.byte_low      = CMD_MEM_WRITE;
                    end
                endcase
            end
            OP_PIXEL: begin
                pkt.packet_prefix   = PFX_DATA;
                pkt.byte_high       = r_item.pixel_value[15:8];
                pkt.byte_low        = r_item.pixel_value[7:0];
                pkt.window_complete = pix_done;
            end
            OP_ROTATION: begin
                if (r_idx == 4'd0) begin
                    pkt.packet_prefix = PFX_CMD;
                    pkt.byte_low      = CMD_MADCTL;
                end else begin
                    pkt.packet_prefix = PFX_DATA;
                    pkt.byte_low      = rot_code(i_rotation_index);
                end
            end
            default: begin
                pkt.packet_prefix = PFX_RESET;
                pkt.byte_high     = (r_idx == 4'd0) ? 8'h01 : 8'h00;
            end
        endcase
    end

    assign o_pkt = pkt;

    // State changes take effect when the item retires.
    always_comb begin
        n_pend_xs    = r_pend_xs;
        n_pend_ys    = r_pend_ys;
        n_pend_xe    = r_pend_xe;
        n_pend_ye    = r_pend_ye;
        n_pend_valid = r_pend_valid;
        n_win_left   = r_win_left;
        n_win_right  = r_win_right;
        n_win_bottom = r_win_bottom;
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_win_open   = r_win_open;
        if (finish) begin
            unique case (r_item.opcode)
                OP_DAMAGE: begin
                    if (i_display_enabled && (xe_c > r_item.x_start)
                            && (ye_c > r_item.y_start)) begin
                        if (r_pend_valid) begin
                            if (r_item.x_start < r_pend_xs) n_pend_xs = r_item.x_start;
                            if (r_item.y_start < r_pend_ys) n_pend_ys = r_item.y_start;
                            if (xe_c > r_pend_xe) n_pend_xe = xe_c;
                            if (ye_c > r_pend_ye) n_pend_ye = ye_c;
                        end else begin
                            n_pend_xs    = r_item.x_start;
                            n_pend_ys    = r_item.y_start;
                            n_pend_xe    = xe_c;
                            n_pend_ye    = ye_c;
                            n_pend_valid = 1'b1;
                        end
                    end
                end
                OP_FLUSH: begin
                    if (npkts != NPKT_NONE) begin
                        n_pend_valid = 1'b0;
                        n_win_left   = r_pend_xs;
                        n_win_right  = r_pend_xe;
                        n_win_bottom = r_pend_ye;
                        n_cur_col    = r_pend_xs;
                        n_cur_row    = r_pend_ys;
                        n_win_open   = 1'b1;
                    end
                end
                OP_PIXEL: begin
                    if (r_win_open) begin
                        if (col_inc >= r_win_right) begin
                            n_cur_col = r_win_left;
                            n_cur_row = row_inc;
                            if (row_inc >= r_win_bottom) n_win_open = 1'b0;
                        end else begin
                            n_cur_col = col_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_idx        <= '0;
            r_pend_xs    <= '0;
            r_pend_ys    <= '0;
            r_pend_xe    <= '0;
            r_pend_ye    <= '0;
            r_pend_valid <= 1'b0;
            r_win_left   <= '0;
            r_win_right  <= '0;
            r_win_bottom <= '0;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_win_open   <= 1'b0;
        end else begin
            r_pend_xs    <= n_pend_xs;
            r_pend_ys    <= n_pend_ys;
            r_pend_xe    <= n_pend_xe;
            r_pend_ye    <= n_pend_ye;
            r_pend_valid <= n_pend_valid;
            r_win_left   <= n_win_left;
            r_win_right  <= n_win_right;
            r_win_bottom <= n_win_bottom;
            r_cur_col    <= n_cur_col;
            r_cur_row    <= n_cur_row;
            r_win_open   <= n_win_open;
            if (o_item_ready) begin
                r_busy <= i_item_valid;
                r_idx  <= '0;
            end else if (step) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_ready && i_item_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hw/rtl/lcd_window_update_packetizer.sv =====
`timescale 1ns / 1ps
// LCD window update packetizer: configuration registers, item register and packet output.
// Depends on lwup_pkg, lwup_core and lwup_out_reg.
//
// Each accepted item sits in the item register until it has made its packets, one packet
// per cycle while the sink keeps up: pixel items make one packet each and stream back to
// back, rotation and panel-reset items make two, a flush that sends its window makes
// eleven, and damage items, ignored items and unknown opcodes make none. The packet
// sequencer in the core sets these counts; a registered output stage holds the current
// beat, so an item retires, and the next is accepted, when its last packet is loaded
// into that stage rather than when the sink takes it. Damage and flush are ignored while
// display_enabled is zero. Registers: display_enabled at byte address 0, rotation_index
// at byte address 4; write them only while the block is idle.
module lcd_window_update_packetizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], x_start[11:3], y_start[20:12], x_end[29:21], y_end[38:30],
    // pixel_value[54:39], zero pad[55]
    input  logic [55:0] s_axis_tdata,
    // packets
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // packet_prefix[7:0], byte_high[15:8], byte_low[23:16]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // window_complete[0]
    output logic        m_axis_tuser
);
    import lwup_pkg::*;

    logic       r_display_enabled;
    logic [1:0] r_rotation_index;
    logic       cfg_wr;
    t_item      item;
    logic       pkt_valid, pkt_ready, out_valid;
    t_pkt       pkt, out_pkt;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_enabled <= 1'b0;
            r_rotation_index  <= 2'd3;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_DISPLAY_ENABLED) begin
                r_display_enabled <= pwdata[0];
            end else begin
                r_rotation_index <= pwdata[1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ROTATION_INDEX) begin
            prdata = {30'd0, r_rotation_index};
        end else begin
            prdata = {31'd0, r_display_enabled};
        end
    end

    assign item.opcode      = t_opcode'(s_axis_tdata[2:0]);
    assign item.x_start     = s_axis_tdata[11:3];
    assign item.y_start     = s_axis_tdata[20:12];
    assign item.x_end       = s_axis_tdata[29:21];
    assign item.y_end       = s_axis_tdata[38:30];
    assign item.pixel_value = s_axis_tdata[54:39];

    lwup_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_display_enabled (r_display_enabled),
        .i_rotation_index  (r_rotation_index),
        .i_item_valid      (s_axis_tvalid),
        .i_item            (item),
        .o_item_ready      (s_axis_tready),
        .o_pkt_valid       (pkt_valid),
        .o_pkt             (pkt),
        .i_pkt_ready       (pkt_ready)
    );

    lwup_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt_valid  (pkt_valid),
        .i_pkt        (pkt),
        .o_ready      (pkt_ready),
        .o_valid      (out_valid),
        .o_pkt        (out_pkt),
        .i_sink_ready (m_axis_tready)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {out_pkt.byte_low, out_pkt.byte_high, out_pkt.packet_prefix};
    assign m_axis_tlast  = out_pkt.last_packet;
    assign m_axis_tuser  = out_pkt.window_complete;

endmodule
